>>> rtl/core/bpt_pkg.sv
// Shared types and constants for the beep pattern timer.
`default_nettype none

package bpt_pkg;

    // Input action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // Profile codes
    localparam logic [1:0] PROF_LIGHT   = 2'd0;
    localparam logic [1:0] PROF_MEDIUM  = 2'd1;
    localparam logic [1:0] PROF_HARD    = 2'd2;
    localparam logic [1:0] PROF_INVALID = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAX_MINUTES   = 3'd0;
    localparam logic [2:0] CFG_LIGHT_ON_MS   = 3'd1;
    localparam logic [2:0] CFG_LIGHT_OFF_MS  = 3'd2;
    localparam logic [2:0] CFG_MEDIUM_ON_MS  = 3'd3;
    localparam logic [2:0] CFG_MEDIUM_OFF_MS = 3'd4;
    localparam logic [2:0] CFG_HARD_ON_MS    = 3'd5;
    localparam logic [2:0] CFG_HARD_OFF_MS   = 3'd6;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned PHASE_W    = 21;
    localparam int unsigned TOTAL_W    = 32;
    localparam int unsigned ELAPSED_W  = 16;

    localparam logic [TOTAL_W-1:0] MS_PER_MINUTE = 32'd60000;

    // Reset values of the phase lengths
    localparam logic [19:0] RST_LIGHT_ON   = 20'd3000;
    localparam logic [19:0] RST_LIGHT_OFF  = 20'd60000;
    localparam logic [19:0] RST_MEDIUM_ON  = 20'd3000;
    localparam logic [19:0] RST_MEDIUM_OFF = 20'd30000;
    localparam logic [19:0] RST_HARD_ON    = 20'd4000;
    localparam logic [19:0] RST_HARD_OFF   = 20'd10000;

    typedef struct packed {
        logic                run_active;
        logic                buzzer_level;
        logic [1:0]          run_profile;
        logic [PHASE_W-1:0]  phase_ms;
        logic [TOTAL_W-1:0]  total_ms;
    } t_run_state;

    // cap_ms holds max_minutes * 60000, zero when the cap is off
    typedef struct packed {
        logic [TOTAL_W-1:0] cap_ms;
        logic [19:0]        light_on_ms;
        logic [19:0]        light_off_ms;
        logic [19:0]        medium_on_ms;
        logic [19:0]        medium_off_ms;
        logic [19:0]        hard_on_ms;
        logic [19:0]        hard_off_ms;
    } t_timer_cfg;

    typedef struct packed {
        logic buzzer_drive;
        logic level_changed;
        logic running;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/bpt_in_if.sv
// Input request channel of the beep pattern timer.
`default_nettype none

interface bpt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [15:0] elapsed_ms;
    logic [1:0] profile;

    modport source (output valid, output action, output elapsed_ms, output profile,
                    input ready);
    modport sink   (input valid, input action, input elapsed_ms, input profile,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/bpt_out_if.sv
// Result channel of the beep pattern timer.
`default_nettype none

interface bpt_out_if;
    logic valid;
    logic ready;
    logic buzzer_drive;
    logic level_changed;
    logic running;

    modport source (output valid, output buzzer_drive, output level_changed,
                    output running, input ready);
    modport sink   (input valid, input buzzer_drive, input level_changed,
                    input running, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bpt_step.sv
// Next-state and result logic for one request of the beep pattern timer.
`default_nettype none

module bpt_step (
    input  wire  bpt_pkg::t_run_state i_state,
    input  wire  bpt_pkg::t_timer_cfg i_cfg,
    input  wire  logic [1:0]          i_action,
    input  wire  logic [15:0]         i_elapsed_ms,
    input  wire  logic [1:0]          i_profile,
    output bpt_pkg::t_run_state       o_state,
    output bpt_pkg::t_result          o_result
);
    import bpt_pkg::*;

    logic [PHASE_W:0]   phase_sum;
    logic [PHASE_W-1:0] phase_sat;
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W-1:0] total_sat;
    logic [19:0]        on_limit;
    logic [19:0]        off_limit;
    logic [19:0]        limit;
    logic               cap_hit;
    logic               phase_done;

    assign phase_sum = {1'b0, i_state.phase_ms} + (PHASE_W+1)'(i_elapsed_ms);
    assign phase_sat = phase_sum[PHASE_W] ? {PHASE_W{1'b1}} : phase_sum[PHASE_W-1:0];
    assign total_sum = {1'b0, i_state.total_ms} + (TOTAL_W+1)'(i_elapsed_ms);
    assign total_sat = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

    always_comb begin
        case (i_state.run_profile)
            PROF_LIGHT: begin
                on_limit  = i_cfg.light_on_ms;
                off_limit = i_cfg.light_off_ms;
            end
            PROF_MEDIUM: begin
                on_limit  = i_cfg.medium_on_ms;
                off_limit = i_cfg.medium_off_ms;
            end
            default: begin
                on_limit  = i_cfg.hard_on_ms;
                off_limit = i_cfg.hard_off_ms;
            end
        endcase
    end

    assign limit      = i_state.buzzer_level ? on_limit : off_limit;
    assign cap_hit    = (i_cfg.cap_ms != '0) && (total_sat >= i_cfg.cap_ms);
    assign phase_done = phase_sat >= PHASE_W'(limit);

    always_comb begin
        o_state = i_state;
        case (i_action)
            ACT_START: begin
                if (i_profile != PROF_INVALID &&
                    !(i_state.run_active && i_state.run_profile == i_profile)) begin
                    o_state.run_active   = 1'b1;
                    o_state.buzzer_level = 1'b1;
                    o_state.run_profile  = i_profile;
                    o_state.phase_ms     = '0;
                    o_state.total_ms     = '0;
                end
            end
            ACT_STOP: begin
                if (i_state.run_active || i_state.buzzer_level) begin
                    o_state = '0;
                end
            end
            ACT_TICK: begin
                if (i_state.run_active) begin
                    o_state.phase_ms = phase_sat;
                    o_state.total_ms = total_sat;
                    // cap wins over the phase compare
                    if (cap_hit) begin
                        o_state.run_active   = 1'b0;
                        o_state.buzzer_level = 1'b0;
                    end else if (phase_done) begin
                        o_state.phase_ms     = '0;
                        o_state.buzzer_level = !i_state.buzzer_level;
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    assign o_result.buzzer_drive  = o_state.buzzer_level;
    assign o_result.level_changed = o_state.buzzer_level != i_state.buzzer_level;
    assign o_result.running       = o_state.run_active;

endmodule

`default_nettype wire

>>> rtl/core/beep_pattern_timer.sv
// Beep pattern timer: run state, configuration registers and result register.
// A result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while the result side takes results; the run
// state updates in a single pass at acceptance and the one result register decouples the output side.
// Reset (synchronous, active low): run cleared, buzzer silent, phase lengths
// at their defaults, cap off, no result pending.
`default_nettype none

module beep_pattern_timer (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [bpt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [bpt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bpt_in_if.sink                           i_in,
    bpt_out_if.source                        o_out
);
    import bpt_pkg::*;

    t_run_state r_state;
    t_run_state n_state;
    t_timer_cfg r_cfg;
    t_result    r_result;
    t_result    n_result;
    logic       r_out_valid;
    logic       in_fire;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    bpt_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_action     (i_in.action),
        .i_elapsed_ms (i_in.elapsed_ms),
        .i_profile    (i_in.profile),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // Configuration registers; the cap is stored in milliseconds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cap_ms        <= '0;
            r_cfg.light_on_ms   <= RST_LIGHT_ON;
            r_cfg.light_off_ms  <= RST_LIGHT_OFF;
            r_cfg.medium_on_ms  <= RST_MEDIUM_ON;
            r_cfg.medium_off_ms <= RST_MEDIUM_OFF;
            r_cfg.hard_on_ms    <= RST_HARD_ON;
            r_cfg.hard_off_ms   <= RST_HARD_OFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_MINUTES:   r_cfg.cap_ms <= TOTAL_W'(i_cfg_data[15:0]) * MS_PER_MINUTE;
                CFG_LIGHT_ON_MS:   r_cfg.light_on_ms   <= i_cfg_data;
                CFG_LIGHT_OFF_MS:  r_cfg.light_off_ms  <= i_cfg_data;
                CFG_MEDIUM_ON_MS:  r_cfg.medium_on_ms  <= i_cfg_data;
                CFG_MEDIUM_OFF_MS: r_cfg.medium_off_ms <= i_cfg_data;
                CFG_HARD_ON_MS:    r_cfg.hard_on_ms    <= i_cfg_data;
                CFG_HARD_OFF_MS:   r_cfg.hard_off_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on every accepted request, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.buzzer_drive  = r_result.buzzer_drive;
    assign o_out.level_changed = r_result.level_changed;
    assign o_out.running       = r_result.running;

`ifndef SYNTHESIS
    a_silent_when_idle: assert property (@(posedge i_clk)
        !r_state.run_active |-> !r_state.buzzer_level)
        else $error("buzzer sounding without an active run");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    a_start_sounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.action == ACT_START && i_in.profile != PROF_INVALID &&
         (!r_state.run_active || r_state.run_profile != i_in.profile))
        |=> (r_state.run_active && r_state.buzzer_level && r_state.total_ms == '0))
        else $error("fresh start did not begin a sounding run");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_fire) |-> (o_out.valid && o_out.running == r_state.run_active &&
                            o_out.buzzer_drive == r_state.buzzer_level))
        else $error("result disagrees with run state");
`endif

endmodule

`default_nettype wire

>>> tb/bpt_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the beep pattern timer: mirrors the run state and checks every result.
module bpt_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bpt_in_if                              i_req,
    bpt_out_if                             i_res,
    output int                             o_fail_count,
    output int                             o_pending
);
    import bpt_pkg::*;

    // Mirrored configuration, indexed by profile: light, medium, hard
    logic [15:0]         cap_minutes;
    logic [19:0]         on_len  [3];
    logic [19:0]         off_len [3];

    // Mirrored run state
    logic                run_on;
    logic                buzz_on;
    logic [1:0]          run_prof;
    logic [PHASE_W-1:0]  phase_acc;
    logic [TOTAL_W-1:0]  total_acc;

    t_result             level_due [$];
    t_result             got;
    t_result             want;
    int                  fail_cnt = 0;
    int                  pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("[%0t] mismatch: %s, got %0d expected %0d", $time, what, got_v, want_v);
        fail_cnt++;
    endtask

    function automatic void clear_run_state();
        run_on    = 1'b0;
        buzz_on   = 1'b0;
        run_prof  = PROF_LIGHT;
        phase_acc = '0;
        total_acc = '0;
    endfunction

    function automatic logic [19:0] phase_len(input logic [1:0] prof, input logic on);
        int p;
        p = (prof == PROF_LIGHT) ? 0 : (prof == PROF_MEDIUM) ? 1 : 2;
        return on ? on_len[p] : off_len[p];
    endfunction

    // Apply one request to the mirrored state and return the level it leaves behind
    function automatic t_result advance_pattern(input logic [1:0] act,
                                                input logic [15:0] dt,
                                                input logic [1:0] prof);
        logic               was_on;
        logic [PHASE_W:0]   phase_sum;
        logic [TOTAL_W:0]   total_sum;
        logic [TOTAL_W-1:0] cap_ms;
        t_result            r;
        was_on = buzz_on;
        cap_ms = {16'd0, cap_minutes} * MS_PER_MINUTE;
        case (act)
            ACT_START: begin
                if (prof != PROF_INVALID && !(run_on && run_prof == prof)) begin
                    clear_run_state();
                    run_on   = 1'b1;
                    run_prof = prof;
                    buzz_on  = 1'b1;
                end
            end
            ACT_STOP: begin
                if (run_on || buzz_on) begin
                    clear_run_state();
                end
            end
            ACT_TICK: begin
                if (run_on) begin
                    phase_sum = {1'b0, phase_acc} + dt;
                    phase_acc = phase_sum[PHASE_W] ? '1 : phase_sum[PHASE_W-1:0];
                    total_sum = {1'b0, total_acc} + dt;
                    total_acc = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                    // the cap wins over the phase compare on the same tick
                    if (cap_minutes != 0 && total_acc >= cap_ms) begin
                        run_on  = 1'b0;
                        buzz_on = 1'b0;
                    end else if (phase_acc >= phase_len(run_prof, buzz_on)) begin
                        phase_acc = '0;
                        buzz_on   = !buzz_on;
                    end
                end
            end
            default: ;
        endcase
        r.buzzer_drive  = buzz_on;
        r.level_changed = buzz_on ^ was_on;
        r.running       = run_on;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cap_minutes = '0;
            on_len[0]   = RST_LIGHT_ON;
            off_len[0]  = RST_LIGHT_OFF;
            on_len[1]   = RST_MEDIUM_ON;
            off_len[1]  = RST_MEDIUM_OFF;
            on_len[2]   = RST_HARD_ON;
            off_len[2]  = RST_HARD_OFF;
            clear_run_state();
            level_due.delete();
        end else begin
            // retire results first so a same-edge request never matches itself
            if (i_res.valid && i_res.ready) begin
                if (level_due.size() == 0) begin
                    report_mismatch("result with no request outstanding", 0, 0);
                end else begin
                    want = level_due.pop_front();
                    got.buzzer_drive  = i_res.buzzer_drive;
                    got.level_changed = i_res.level_changed;
                    got.running       = i_res.running;
                    if (got.buzzer_drive !== want.buzzer_drive) begin
                        report_mismatch("buzzer_drive", got.buzzer_drive, want.buzzer_drive);
                    end
                    if (got.level_changed !== want.level_changed) begin
                        report_mismatch("level_changed", got.level_changed,
                                        want.level_changed);
                    end
                    if (got.running !== want.running) begin
                        report_mismatch("running", got.running, want.running);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                level_due.push_back(advance_pattern(i_req.action, i_req.elapsed_ms,
                                                    i_req.profile));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_MINUTES:   cap_minutes = i_cfg_data[15:0];
                    CFG_LIGHT_ON_MS:   on_len[0]   = i_cfg_data;
                    CFG_LIGHT_OFF_MS:  off_len[0]  = i_cfg_data;
                    CFG_MEDIUM_ON_MS:  on_len[1]   = i_cfg_data;
                    CFG_MEDIUM_OFF_MS: off_len[1]  = i_cfg_data;
                    CFG_HARD_ON_MS:    on_len[2]   = i_cfg_data;
                    CFG_HARD_OFF_MS:   off_len[2]  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending_cnt = level_due.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the beep pattern timer: clock, reset, stimulus and verdict.
module tb;
    import bpt_pkg::*;

    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int SOAK_TICKS        = 16;
    localparam int ITEMS_PER_SETTING = 140;
    localparam int SETTING_COUNT     = 5;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int idle_max = 16;
    int fail_count;
    int pending;
    int cycle_cnt;

    bpt_in_if  req_ch ();
    bpt_out_if res_ch ();

    beep_pattern_timer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (req_ch),
        .o_out       (res_ch)
    );

    bpt_checker u_score (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb failed");
        $finish;
    end

    // Result side: stall a random number of cycles before taking each result
    initial begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        forever begin
            stall = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
            if (stall > 0) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    task automatic send_req(input logic [1:0] act, input logic [15:0] dt,
                            input logic [1:0] prof);
        int gap;
        gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.elapsed_ms <= dt;
        req_ch.profile    <= prof;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Drop the request and hold until every result is back
    task automatic wait_drained;
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_setting(input int k);
        logic [CFG_DATA_W-1:0] cap_val;
        logic [CFG_DATA_W-1:0] len;
        case (k)
            1:       cap_val = CFG_DATA_W'($urandom_range(1, 5));
            2:       cap_val = 20'h0FFFF;
            3:       cap_val = '0;
            default: cap_val = CFG_DATA_W'($urandom_range(0, 200));
        endcase
        write_reg(CFG_MAX_MINUTES, cap_val);
        for (int r = CFG_LIGHT_ON_MS; r <= CFG_HARD_OFF_MS; r++) begin
            case (k)
                1:       len = CFG_DATA_W'($urandom_range(0, 20000));
                2:       len = '1;
                3:       len = '0;
                default: len = CFG_DATA_W'($urandom());
            endcase
            write_reg(CFG_IDX_W'(r), len);
        end
    endtask

    // Mostly ticks inside running patterns, with restarts, stops and noise mixed in
    task automatic send_random_req(output bit counted);
        logic [1:0]  act;
        logic [1:0]  prof;
        logic [15:0] dt;
        int          pick;
        pick = $urandom_range(0, 99);
        act = (pick < 70) ? ACT_TICK : (pick < 85) ? ACT_START :
              (pick < 92) ? ACT_STOP : ACT_UNUSED;
        case ($urandom_range(0, 3))
            0:       dt = 16'($urandom_range(0, 255));
            1:       dt = 16'($urandom());
            2:       dt = 16'($urandom_range(0, 4095));
            default: dt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        prof = 2'($urandom_range(0, 3));
        counted = !(act == ACT_UNUSED || (act == ACT_START && prof == PROF_INVALID));
        send_req(act, dt, prof);
    endtask

    initial begin
        int  count;
        int  n;
        bit  counted;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_TICK;
        req_ch.elapsed_ms = '0;
        req_ch.profile    = PROF_LIGHT;
        cfg_we            = 1'b0;
        cfg_index         = CFG_MAX_MINUTES;
        cfg_data          = '0;
        i_rst_n           = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle requests, noise and an invalid start change nothing
        send_req(ACT_TICK, 16'hFFFF, PROF_HARD);
        send_req(ACT_STOP, 16'h0000, PROF_LIGHT);
        send_req(ACT_UNUSED, 16'hA5A5, PROF_INVALID);
        send_req(ACT_START, 16'h5A5A, PROF_INVALID);
        // light run; a repeated start for it is ignored
        send_req(ACT_START, 16'h0000, PROF_LIGHT);
        send_req(ACT_START, 16'h1234, PROF_LIGHT);
        send_req(ACT_TICK, 16'd2999, PROF_LIGHT);
        send_req(ACT_TICK, 16'd1, PROF_LIGHT);
        // switch profiles mid-run
        send_req(ACT_START, 16'h0000, PROF_MEDIUM);
        send_req(ACT_TICK, 16'd3000, PROF_LIGHT);
        send_req(ACT_TICK, 16'd30000, PROF_LIGHT);
        send_req(ACT_START, 16'h0000, PROF_HARD);
        send_req(ACT_TICK, 16'd4000, PROF_LIGHT);
        send_req(ACT_TICK, 16'd0, PROF_LIGHT);
        send_req(ACT_UNUSED, 16'hFFFF, PROF_MEDIUM);
        send_req(ACT_STOP, 16'h0000, PROF_LIGHT);
        send_req(ACT_STOP, 16'h0000, PROF_LIGHT);

        // zero phase lengths toggle on every tick; a one-minute cap ends the run
        write_reg(CFG_MAX_MINUTES, 20'd1);
        write_reg(CFG_LIGHT_ON_MS, 20'd0);
        write_reg(CFG_LIGHT_OFF_MS, 20'd0);
        send_req(ACT_START, 16'h0000, PROF_LIGHT);
        send_req(ACT_TICK, 16'd0, PROF_LIGHT);
        send_req(ACT_TICK, 16'd0, PROF_LIGHT);
        send_req(ACT_TICK, 16'hFFFF, PROF_LIGHT);
        send_req(ACT_TICK, 16'd100, PROF_LIGHT);
        send_req(ACT_STOP, 16'h0000, PROF_LIGHT);
        send_req(ACT_START, 16'h0000, PROF_LIGHT);

        for (int k = 0; k < SETTING_COUNT; k++) begin
            if (k > 0) begin
                apply_setting(k);
            end
            count = 0;
            n = 0;
            while (count < ITEMS_PER_SETTING) begin
                if (n % 40 == 0) begin
                    idle_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
                end
                if (n == 85) begin
                    wait_drained();
                end
                send_random_req(counted);
                count += counted;
                n++;
            end
        end

        // back-to-back long ticks with no cap, then cap at the maximum
        idle_max = 0;
        write_reg(CFG_MAX_MINUTES, 20'd0);
        send_req(ACT_STOP, 16'h0000, PROF_LIGHT);
        send_req(ACT_START, 16'h0000, PROF_MEDIUM);
        repeat (SOAK_TICKS) send_req(ACT_TICK, 16'hFFFF, PROF_LIGHT);
        write_reg(CFG_MAX_MINUTES, 20'h0FFFF);
        idle_max = 16;
        send_req(ACT_TICK, 16'd1, PROF_LIGHT);
        send_req(ACT_TICK, 16'd1, PROF_LIGHT);
        send_req(ACT_START, 16'h0000, PROF_HARD);

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bpt_pkg.sv
rtl/core/bpt_in_if.sv
rtl/core/bpt_out_if.sv
rtl/core/bpt_step.sv
rtl/core/beep_pattern_timer.sv
tb/bpt_checker.sv
tb/tb.sv
